>>> rtl/lrtks_pkg.sv
// shared constants and controller command type for the top-k region selector
`timescale 1ns / 1ps

package lrtks_pkg;

  localparam int AREA_W        = 24;
  localparam int CEILING_RESET = 1000000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // an input transaction is taken this cycle
    logic load;       // load output register from list head and shift list
    logic first;      // first slot of the ranked run
    logic last_slot;  // slot being loaded is the final one
  } cmd_t;

endpackage

>>> rtl/largest_region_top_k_select.sv
// top level of the top-k largest region selector
`timescale 1ns / 1ps

// Region areas arrive one per transaction in label order; the first of a
// frame is the background (label 0) and only its area is kept. Each later
// region gets the next label. Regions with nonzero area not above
// area_ceiling are inserted into a sorted chain of TOP_COUNT cells (area
// descending, ties by ascending label), one compare per cell, so one
// transaction is taken every cycle while a frame streams in. On the
// transaction with tlast the block stops accepting, then emits TOP_COUNT
// ranked results, one per cycle while m_axis_tready is high, by shifting the
// chain through an output register. Slots beyond the qualifying regions
// repeat the last one, or give label 0 with the background area, with tuser
// set as a filler flag. Once label 2^LABEL_BITS-1 is handed out, remaining
// regions of the frame are ignored. area_ceiling resets to 1000000.

module largest_region_top_k_select #(
  parameter int TOP_COUNT  = 25,
  parameter int LABEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lrtks_pkg::AREA_W-1:0]  s_axis_tdata,   // [23:0] area
  input  logic                          s_axis_tlast,   // final region of frame
  // ranked output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // label, then region_area
  output logic [((LABEL_BITS + lrtks_pkg::AREA_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                          m_axis_tuser,   // filler
  output logic                          m_axis_tlast,   // final slot of run
  // area ceiling register
  input  logic                          cfg_wr_en,
  input  logic [lrtks_pkg::AREA_W-1:0]  cfg_wr_data
);

  localparam int PAYLOAD_W = LABEL_BITS + lrtks_pkg::AREA_W;
  localparam int M_DATA_W  = ((PAYLOAD_W + 7) / 8) * 8;

  lrtks_pkg::cmd_t              cmd;
  logic [LABEL_BITS-1:0]        out_label;
  logic [lrtks_pkg::AREA_W-1:0] out_area;

  // sequencing: accept, load head, walk the output slots
  lrtks_ctrl #(
    .TOP_COUNT (TOP_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // sorted chain, label counter, output register
  lrtks_datapath #(
    .TOP_COUNT  (TOP_COUNT),
    .LABEL_BITS (LABEL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_area     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_label   (out_label),
    .out_area    (out_area),
    .out_filler  (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

  // pack label in the low bits, area above, zero fill to whole bytes
  assign m_axis_tdata = M_DATA_W'({out_area, out_label});

endmodule

>>> rtl/lrtks_datapath.sv
// sorted insertion chain, label counter and output register
`timescale 1ns / 1ps

module lrtks_datapath #(
  parameter int TOP_COUNT  = 25,
  parameter int LABEL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lrtks_pkg::cmd_t             cmd,
  input  logic [lrtks_pkg::AREA_W-1:0] in_area,
  input  logic                        in_last,
  input  logic                        cfg_wr_en,
  input  logic [lrtks_pkg::AREA_W-1:0] cfg_wr_data,
  output logic [LABEL_BITS-1:0]       out_label,
  output logic [lrtks_pkg::AREA_W-1:0] out_area,
  output logic                        out_filler,
  output logic                        out_last
);

  localparam logic [LABEL_BITS-1:0] LABEL_MAX = {LABEL_BITS{1'b1}};

  logic [lrtks_pkg::AREA_W-1:0] cell_area  [TOP_COUNT];
  logic [LABEL_BITS-1:0]        cell_label [TOP_COUNT];
  logic [TOP_COUNT-1:0]         cell_valid;
  logic [TOP_COUNT-1:0]         ge;

  logic [lrtks_pkg::AREA_W-1:0] area_ceiling;
  logic [lrtks_pkg::AREA_W-1:0] background_area;
  logic [LABEL_BITS-1:0]        next_label;
  logic                         label_full;

  logic is_background;
  logic ins;

  assign is_background = (next_label == '0) && !label_full;
  assign ins = cmd.accept && !is_background && !label_full && (in_area != '0) &&
               (in_area <= area_ceiling);

  // each cell keeps its entry while it ranks at or above the new area
  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      ge[i] = cell_valid[i] && (cell_area[i] >= in_area);
    end
  end

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    logic take_new;
    logic [lrtks_pkg::AREA_W-1:0] up_area;
    logic [LABEL_BITS-1:0]        up_label;
    logic                         up_valid;
    logic [lrtks_pkg::AREA_W-1:0] dn_area;
    logic [LABEL_BITS-1:0]        dn_label;
    logic                         dn_valid;

    // neighbor toward the head (insertion shifts from there)
    if (i == 0) begin : g_head
      assign take_new = 1'b1;
      assign up_area  = in_area;
      assign up_label = next_label;
      assign up_valid = 1'b1;
    end else begin : g_body
      assign take_new = ge[i-1];
      assign up_area  = cell_area[i-1];
      assign up_label = cell_label[i-1];
      assign up_valid = cell_valid[i-1];
    end

    // neighbor toward the tail (readout shifts from there)
    if (i == TOP_COUNT - 1) begin : g_tail
      assign dn_area  = cell_area[i];
      assign dn_label = cell_label[i];
      assign dn_valid = 1'b0;
    end else begin : g_inner
      assign dn_area  = cell_area[i+1];
      assign dn_label = cell_label[i+1];
      assign dn_valid = cell_valid[i+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cell_valid[i] <= 1'b0;
      end else if (cmd.load) begin
        cell_valid[i] <= dn_valid;
      end else if (ins && !ge[i]) begin
        cell_valid[i] <= take_new ? 1'b1 : up_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        cell_area[i]  <= dn_area;
        cell_label[i] <= dn_label;
      end else if (ins && !ge[i]) begin
        cell_area[i]  <= take_new ? in_area : up_area;
        cell_label[i] <= take_new ? next_label : up_label;
      end
    end
  end

  // label counter and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      next_label   <= '0;
      label_full   <= 1'b0;
      area_ceiling <= lrtks_pkg::AREA_W'(lrtks_pkg::CEILING_RESET);
    end else begin
      if (cfg_wr_en) begin
        area_ceiling <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (in_last) begin
          next_label <= '0;
          label_full <= 1'b0;
        end else if (is_background) begin
          next_label <= LABEL_BITS'(1);
        end else if (!label_full) begin
          if (next_label == LABEL_MAX) begin
            label_full <= 1'b1;
          end else begin
            next_label <= next_label + LABEL_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_background) begin
      background_area <= in_area;
    end
  end

  // output register: head entry, else repeat of the last one, else background
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_last <= cmd.last_slot;
      if (cell_valid[0]) begin
        out_label  <= cell_label[0];
        out_area   <= cell_area[0];
        out_filler <= 1'b0;
      end else begin
        out_filler <= 1'b1;
        if (cmd.first) begin
          out_label <= '0;
          out_area  <= background_area;
        end
      end
    end
  end

endmodule

>>> rtl/lrtks_ctrl.sv
// controller: input acceptance and ranked readout sequencing
`timescale 1ns / 1ps

module lrtks_ctrl #(
  parameter int TOP_COUNT = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lrtks_pkg::cmd_t cmd
);

  localparam int SLOT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TOP_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
      end
      S_LOAD: begin
        cmd.load      = 1'b1;
        cmd.first     = 1'b1;
        cmd.last_slot = (slot == SLOT_LAST);
      end
      S_EMIT: begin
        if (out_ready && (slot != SLOT_LAST)) begin
          cmd.load      = 1'b1;
          cmd.last_slot = ((slot + SLOT_W'(1)) == SLOT_LAST);
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_last) begin
            state <= S_LOAD;
            slot  <= '0;
          end
        end
        S_LOAD: begin
          state     <= S_EMIT;
          out_valid <= 1'b1;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (slot == SLOT_LAST) begin
              state     <= S_IDLE;
              out_valid <= 1'b0;
            end else begin
              slot <= slot + SLOT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the top-k largest region selector
`timescale 1ns / 1ps

// Streams frames of region areas into the selector and checks every ranked
// slot that comes back. A behavioral copy of the ranking (sorted insertion,
// area descending, ties by ascending label) runs at each accepted input
// transaction and queues the TOP_COUNT slots that a tlast transaction causes.
// The result process compares each output transaction with the oldest queued
// slot. The area ceiling is rewritten only once the block has drained.
//
// Test order:
//   background-only frames, ties and the ceiling boundary, ceiling extremes,
//   random frames in three idle phases.

module tb_top;

  localparam int AREA_W      = lrtks_pkg::AREA_W;
  localparam int TOPK        = 25;
  localparam int LABEL_W     = 16;
  localparam int LABEL_LIMIT = (1 << LABEL_W) - 1;
  localparam int M_W         = LABEL_W + AREA_W;   // 40 bits, whole bytes
  // cycles after the last slot before the block is surely idle
  localparam int SETTLE      = 4;
  // longest run of cycles with no transaction on either side
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [LABEL_W-1:0] label;
    logic [AREA_W-1:0]  area;
    logic               filler;
    logic               last_slot;
  } slot_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [AREA_W-1:0]   s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_W-1:0]      m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_wr_en;
  logic [AREA_W-1:0]   cfg_wr_data;

  // ranking copy: ceiling, ranked list and frame counters
  logic [AREA_W-1:0]   ceiling;
  logic [AREA_W-1:0]   kept_area [TOPK];
  logic [LABEL_W-1:0]  kept_label [TOPK];
  int                  kept_n;
  int                  label_next;
  bit                  labels_done;
  logic [AREA_W-1:0]   bg_area;

  slot_t               ranked_slots [$];   // slots still to come from the block
  logic [AREA_W-1:0]   frame_areas [$];    // background first, then regions
  int                  gap_pct;            // sender idle chance, percent
  int                  stall_pct;          // receiver idle chance, percent
  int                  fail_count = 0;
  int                  quiet_cycles = 0;

  always #5 clk = ~clk;

  largest_region_top_k_select #(
    .TOP_COUNT  (TOPK),
    .LABEL_BITS (LABEL_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),     // [23:0] area
    .s_axis_tlast  (s_axis_tlast),     // final region of frame
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),     // [15:0] label, [39:16] region_area
    .m_axis_tuser  (m_axis_tuser),     // filler
    .m_axis_tlast  (m_axis_tlast),     // final slot of run
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // ---------------------------------------------------------------------
  // ranking copy, run once per accepted input transaction
  // ---------------------------------------------------------------------
  function automatic void rank_region(logic [AREA_W-1:0] a, logic is_last);
    int    pos;
    int    k;
    int    lab;
    slot_t s;
    if (label_next == 0 && !labels_done) begin
      // background region, label 0: only its area is kept
      bg_area    = a;
      label_next = 1;
    end else if (!labels_done) begin
      lab = label_next;
      if (a != '0 && a <= ceiling) begin
        pos = 0;
        while (pos < kept_n && kept_area[pos] >= a) pos++;
        if (pos < TOPK) begin
          // open a hole at pos, dropping the tail when the list is full
          k = (kept_n < TOPK) ? kept_n : TOPK - 1;
          while (k > pos) begin
            kept_area[k]  = kept_area[k-1];
            kept_label[k] = kept_label[k-1];
            k--;
          end
          kept_area[pos]  = a;
          kept_label[pos] = lab[LABEL_W-1:0];
          if (kept_n < TOPK) kept_n++;
        end
      end
      // once the largest label is out, the rest of the frame is ignored
      if (lab >= LABEL_LIMIT) labels_done = 1'b1;
      else label_next = lab + 1;
    end

    if (is_last) begin
      for (int i = 0; i < TOPK; i++) begin
        if (i < kept_n) begin
          s.label  = kept_label[i];
          s.area   = kept_area[i];
          s.filler = 1'b0;
        end else if (kept_n > 0) begin
          // too few regions qualified: repeat the last kept one
          s.label  = kept_label[kept_n-1];
          s.area   = kept_area[kept_n-1];
          s.filler = 1'b1;
        end else begin
          // nothing qualified: label 0 with the background area
          s.label  = '0;
          s.area   = bg_area;
          s.filler = 1'b1;
        end
        s.last_slot = (i == TOPK - 1);
        ranked_slots = {ranked_slots, s};
      end
      kept_n      = 0;
      label_next  = 0;
      labels_done = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_slots
    slot_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (ranked_slots.size() == 0) begin
        report_mismatch("unexpected result transaction, label",
                        32'(m_axis_tdata[LABEL_W-1:0]), 32'd0);
      end else begin
        want = ranked_slots.pop_front();
        if (m_axis_tdata[LABEL_W-1:0] !== want.label)
          report_mismatch("label", 32'(m_axis_tdata[LABEL_W-1:0]), 32'(want.label));
        if (m_axis_tdata[M_W-1:LABEL_W] !== want.area)
          report_mismatch("region_area", 32'(m_axis_tdata[M_W-1:LABEL_W]),
                          32'(want.area));
        if (m_axis_tuser !== want.filler)
          report_mismatch("filler", 32'(m_axis_tuser), 32'(want.filler));
        if (m_axis_tlast !== want.last_slot)
          report_mismatch("last_res", 32'(m_axis_tlast), 32'(want.last_slot));
      end
    end
  end

  // ends the run if neither side moves a transaction for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("** largest_region_top_k_select: FAILED **");
        $finish;
      end
    end
  end

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------
  // drivers; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_region(input logic [AREA_W-1:0] a, input logic is_last);
    // random sender gap before the transaction
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= a;
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    rank_region(a, is_last);
    @(negedge clk);
  endtask

  // sends frame_areas as one frame, tlast on the final entry, then empties it
  task automatic send_frame();
    for (int i = 0; i < frame_areas.size(); i++)
      send_region(frame_areas[i], i == frame_areas.size() - 1);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    frame_areas.delete();
  endtask

  task automatic wait_drain();
    while (ranked_slots.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // ceiling writes happen only with the block idle
  task automatic write_ceiling(input logic [AREA_W-1:0] value);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    ceiling      = value;
  endtask

  function automatic logic [AREA_W-1:0] pick_ceiling();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return AREA_W'(lrtks_pkg::CEILING_RESET);
      3:       return AREA_W'($urandom_range(1, 16));
      default: return AREA_W'($urandom);
    endcase
  endfunction

  // area mix aimed at ties, the ceiling boundary and the field extremes
  function automatic logic [AREA_W-1:0] pick_area();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return AREA_W'($urandom_range(1, 8));
      3:       return ceiling;
      4:       return (ceiling == '1) ? ceiling : ceiling + 1'b1;
      5:       return '1;
      6:       return AREA_W'($urandom_range(1, 2000000));
      default: return AREA_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_background_only();
    frame_areas = '{24'hFFFFFF};
    send_frame();
    frame_areas = '{24'h000000};
    send_frame();
  endtask

  // reset ceiling: ties at the ceiling, one above it, zero and the smallest area
  task automatic test_ties_and_ceiling();
    frame_areas = '{24'd5, 24'd0, 24'd1000001, 24'd1000000, 24'd1, 24'd1000000,
                    24'hFFFFFF};
    send_frame();
  endtask

  task automatic test_ceiling_extremes();
    write_ceiling('1);
    frame_areas = '{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd7};
    send_frame();
    // ceiling 0: nothing qualifies, slots carry the background area
    write_ceiling('0);
    frame_areas = '{24'd3, 24'd1, 24'hFFFFFF};
    send_frame();
  endtask

  task automatic test_random_frames(input int gap, input int stall, input int quota);
    int sent;
    int n;
    sent      = 0;
    gap_pct   = gap;
    stall_pct = stall;
    while (sent < quota) begin
      if ($urandom_range(99) < 30) write_ceiling(pick_ceiling());
      case ($urandom_range(9))
        0:       n = 0;
        1, 2:    n = $urandom_range(31, 60);
        default: n = $urandom_range(1, 30);
      endcase
      for (int i = 0; i <= n; i++) frame_areas = {frame_areas, pick_area()};
      sent += n + 1;
      send_frame();
    end
  endtask

  // ---------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    gap_pct       = 35;
    stall_pct     = 68;
    ceiling       = AREA_W'(lrtks_pkg::CEILING_RESET);
    kept_n        = 0;
    label_next    = 0;
    labels_done   = 1'b0;
    bg_area       = '0;
    for (int i = 0; i < TOPK; i++) begin
      kept_area[i]  = '0;
      kept_label[i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_background_only();
    test_ties_and_ceiling();
    test_ceiling_extremes();
    test_random_frames(35, 68, 125);
    test_random_frames(68, 35, 125);
    test_random_frames(0, 0, 125);

    wait_drain();
    // anything that still comes out now is an unexpected result
    repeat (30) @(negedge clk);
    if (fail_count == 0)
      $display("** largest_region_top_k_select: PASSED **");
    else
      $display("** largest_region_top_k_select: FAILED **");
    $finish;
  end

endmodule

>>> largest_region_top_k_select.f
rtl/lrtks_pkg.sv
rtl/lrtks_datapath.sv
rtl/lrtks_ctrl.sv
rtl/largest_region_top_k_select.sv
tb/tb_top.sv
